### design/tsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the three-set fuzzifier.
// No dependencies; every other design file refers to this package by scope.
package tsf_pkg;

  localparam int WORD_W    = 32;
  localparam int GRADE_W   = 17;
  localparam int CFG_IDX_W = 2;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_HIGH = 2'd2;

  localparam logic [WORD_W-1:0] ANCHOR_LOW_RST  = 32'd65536;
  localparam logic [WORD_W-1:0] ANCHOR_MID_RST  = 32'd131072;
  localparam logic [WORD_W-1:0] ANCHOR_HIGH_RST = 32'd196608;

  // Queue between classifier and divider back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // What the back end has to build from the quotient
  typedef enum logic [1:0] {
    KIND_SIM_ONE  = 2'd0, // similar is 1.0, the rest 0
    KIND_VERY_ONE = 2'd1, // very is 1.0, the rest 0
    KIND_LOW_SEG  = 2'd2, // somewhat = q, similar = complement
    KIND_HIGH_SEG = 2'd3  // very = q, somewhat = complement
  } kind_t;

  typedef struct packed {
    logic              crisp;
    kind_t             kind;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] span;
  } job_t;

endpackage

### design/tsf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: distance input, grade output, register writes.
// Depends on tsf_pkg for field widths.
interface tsf_in_if;
  logic                      valid;
  logic                      ready;
  logic [tsf_pkg::WORD_W-1:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface tsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsf_pkg::GRADE_W-1:0] grade_similar;
  logic [tsf_pkg::GRADE_W-1:0] grade_somewhat;
  logic [tsf_pkg::GRADE_W-1:0] grade_very;
  logic                        crisp_fallback;
  modport source (output valid, output grade_similar, output grade_somewhat,
                  output grade_very, output crisp_fallback, input ready);
  modport sink   (input valid, input grade_similar, input grade_somewhat,
                  input grade_very, input crisp_fallback, output ready);
endinterface

interface tsf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsf_pkg::CFG_IDX_W-1:0] index;
  logic [tsf_pkg::WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/three_set_fuzzifier.sv
`timescale 1ns / 1ps
// Three-set fuzzifier: a request passes the front register, the queue, one
// divider register stage per quotient bit and the output register before its
// result is valid. Throughput one request per cycle while the result side keeps
// taking results. Reset (synchronous, rst_n low) empties the pipe and queue and
// loads the anchors with 1.0, 2.0 and 3.0; no clearing pass is needed.
module three_set_fuzzifier #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tsf_in_if.sink     in_ch,
  tsf_out_if.source  out_ch,
  tsf_cfg_if.sink    cfg_ch
);

  logic          push, q_full, pop, head_vld;
  tsf_pkg::job_t push_job, head_job;

  tsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  tsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  tsf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head_job (head_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### design/tsf_front.sv
`timescale 1ns / 1ps
// Front end: anchor registers, request intake and region classification.
// Depends on tsf_pkg and the channel interfaces in tsf_if.sv.
module tsf_front (
  input  logic              clk,
  input  logic              rst_n,
  tsf_in_if.sink            in_ch,
  tsf_cfg_if.sink           cfg_ch,
  input  logic              q_full,
  output logic              push,
  output tsf_pkg::job_t     push_job
);

  logic [tsf_pkg::WORD_W-1:0] lo_r, mid_r, hi_r;
  logic                       front_vld_r, front_vld_nxt;
  tsf_pkg::job_t              front_job_r, job_nxt;
  logic                       accept;
  logic [tsf_pkg::WORD_W-1:0] d;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= tsf_pkg::ANCHOR_LOW_RST;
      mid_r <= tsf_pkg::ANCHOR_MID_RST;
      hi_r  <= tsf_pkg::ANCHOR_HIGH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tsf_pkg::REG_ANCHOR_LOW:  lo_r  <= cfg_ch.data;
        tsf_pkg::REG_ANCHOR_MID:  mid_r <= cfg_ch.data;
        tsf_pkg::REG_ANCHOR_HIGH: hi_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign push         = front_vld_r && !q_full;
  assign push_job     = front_job_r;
  assign in_ch.ready  = !front_vld_r || !q_full;
  assign accept       = in_ch.valid && in_ch.ready;
  assign d            = in_ch.distance;

  // Pick the segment; the back end only ever divides within one span
  always_comb begin
    job_nxt.crisp = (mid_r <= lo_r) || (hi_r <= mid_r);
    job_nxt.kind  = tsf_pkg::KIND_SIM_ONE;
    job_nxt.num   = '0;
    job_nxt.span  = 32'd1;
    if (job_nxt.crisp) begin
      job_nxt.kind = (d <= mid_r) ? tsf_pkg::KIND_SIM_ONE : tsf_pkg::KIND_VERY_ONE;
    end else if (d <= lo_r) begin
      job_nxt.kind = tsf_pkg::KIND_SIM_ONE;
    end else if (d < mid_r) begin
      job_nxt.kind = tsf_pkg::KIND_LOW_SEG;
      job_nxt.num  = d - lo_r;
      job_nxt.span = mid_r - lo_r;
    end else if (d < hi_r) begin
      job_nxt.kind = tsf_pkg::KIND_HIGH_SEG;
      job_nxt.num  = d - mid_r;
      job_nxt.span = hi_r - mid_r;
    end else begin
      job_nxt.kind = tsf_pkg::KIND_VERY_ONE;
    end
  end

  always_comb begin
    front_vld_nxt = front_vld_r;
    if (accept) begin
      front_vld_nxt = 1'b1;
    end else if (push) begin
      front_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else begin
      front_vld_r <= front_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_job_r <= job_nxt;
    end
  end

endmodule

### design/tsf_queue.sv
`timescale 1ns / 1ps
// Short request queue decoupling the classifier from the divider pipeline.
// Depends on tsf_pkg for the job type and depth constants.
module tsf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_vld,
  output tsf_pkg::job_t head_job
);

  tsf_pkg::job_t               mem_r [tsf_pkg::QUEUE_DEPTH];
  logic [tsf_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tsf_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_pop;

  assign full     = (cnt_r == tsf_pkg::QCNT_W'(tsf_pkg::QUEUE_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_pop   = pop && head_vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/tsf_back.sv
`timescale 1ns / 1ps
// Back end: pipelined restoring divider, one quotient bit per stage, then grade
// assembly into the output register. Depends on tsf_pkg and tsf_out_if.
module tsf_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_vld,
  input  tsf_pkg::job_t head_job,
  output logic          pop,
  tsf_out_if.source     out_ch
);

  localparam int GW = FRAC_BITS + 1;

  typedef struct packed {
    logic                       crisp;
    tsf_pkg::kind_t             kind;
    logic [tsf_pkg::WORD_W-1:0] span;
    logic [tsf_pkg::WORD_W-1:0] rem;
    logic [FRAC_BITS-1:0]       quo;
  } stg_t;

  stg_t stg_r   [FRAC_BITS];
  logic vld_r   [FRAC_BITS];
  logic en;

  // Whole pipe moves together whenever the output register can take a result
  assign en  = !out_ch.valid || out_ch.ready;
  assign pop = en && head_vld;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
    stg_t                        prev, stg_nxt;
    logic                        prev_v;
    logic [tsf_pkg::WORD_W:0]    rem2;
    logic                        ge;

    if (i == 0) begin : g_first
      always_comb begin
        prev_v     = head_vld;
        prev.crisp = head_job.crisp;
        prev.kind  = head_job.kind;
        prev.span  = head_job.span;
        prev.rem   = head_job.num;
        prev.quo   = '0;
      end
    end else begin : g_next
      assign prev_v = vld_r[i-1];
      assign prev   = stg_r[i-1];
    end

    // rem < span holds throughout, so the new remainder fits the word
    always_comb begin
      rem2          = {prev.rem, 1'b0};
      ge            = rem2 >= {1'b0, prev.span};
      stg_nxt       = prev;
      stg_nxt.rem   = ge ? tsf_pkg::WORD_W'(rem2 - {1'b0, prev.span})
                         : rem2[tsf_pkg::WORD_W-1:0];
      stg_nxt.quo   = {prev.quo[FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[i] <= stg_nxt;
      end
    end
  end

  stg_t          last;
  logic [GW-1:0] one, q_ext, comp;
  logic [GW-1:0] sim, some, very;
  logic          out_vld_r;
  logic [tsf_pkg::GRADE_W-1:0] sim_r, some_r, very_r;
  logic          crisp_r;

  assign last  = stg_r[FRAC_BITS-1];
  assign one   = GW'(1) << FRAC_BITS;
  assign q_ext = GW'(last.quo);
  // floor((span - n) * 2^F / span) = 2^F - q - (remainder != 0)
  assign comp  = one - q_ext - GW'(|last.rem);

  always_comb begin
    sim  = '0;
    some = '0;
    very = '0;
    case (last.kind)
      tsf_pkg::KIND_SIM_ONE:  sim = one;
      tsf_pkg::KIND_VERY_ONE: very = one;
      tsf_pkg::KIND_LOW_SEG: begin
        some = q_ext;
        sim  = comp;
      end
      tsf_pkg::KIND_HIGH_SEG: begin
        very = q_ext;
        some = comp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sim_r   <= tsf_pkg::GRADE_W'(sim);
      some_r  <= tsf_pkg::GRADE_W'(some);
      very_r  <= tsf_pkg::GRADE_W'(very);
      crisp_r <= last.crisp;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.grade_similar  = sim_r;
  assign out_ch.grade_somewhat = some_r;
  assign out_ch.grade_very     = very_r;
  assign out_ch.crisp_fallback = crisp_r;

endmodule

### tb/three_set_fuzzifier_checker.sv
`timescale 1ns / 1ps
// Checker for the three-set fuzzifier: watches the distance, grade and anchor channels,
// predicts the grades of each accepted request and compares them in order.
// Depends on tsf_pkg and the channel interfaces in tsf_if.sv.
module three_set_fuzzifier_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tsf_in_if           in_ch,
  tsf_out_if          out_ch,
  tsf_cfg_if          cfg_ch,
  output int unsigned n_fail,
  output int unsigned n_pending
);

  localparam logic [63:0]                 UNIT_WIDE = 64'd1 << FRAC_BITS;
  localparam logic [tsf_pkg::GRADE_W-1:0] GRADE_ONE = UNIT_WIDE[tsf_pkg::GRADE_W-1:0];

  typedef struct packed {
    logic [tsf_pkg::WORD_W-1:0]  dist_val;
    logic [tsf_pkg::GRADE_W-1:0] similar;
    logic [tsf_pkg::GRADE_W-1:0] somewhat;
    logic [tsf_pkg::GRADE_W-1:0] very;
    logic                        crisp;
  } grade_set_t;

  logic [tsf_pkg::WORD_W-1:0] anchor_low  = tsf_pkg::ANCHOR_LOW_RST;
  logic [tsf_pkg::WORD_W-1:0] anchor_mid  = tsf_pkg::ANCHOR_MID_RST;
  logic [tsf_pkg::WORD_W-1:0] anchor_high = tsf_pkg::ANCHOR_HIGH_RST;
  grade_set_t                 grades_due[$];
  int unsigned                fails = 0;

  assign n_fail = fails;

  // floor(num * 2^FRAC_BITS / span), cut to the output width
  function automatic logic [tsf_pkg::GRADE_W-1:0] scaled_ratio(
      logic [tsf_pkg::WORD_W-1:0] num, logic [tsf_pkg::WORD_W-1:0] span);
    logic [63:0] wide;
    wide = (64'(num) << FRAC_BITS) / 64'(span);
    return wide[tsf_pkg::GRADE_W-1:0];
  endfunction

  function automatic grade_set_t fuzzify(logic [tsf_pkg::WORD_W-1:0] d);
    grade_set_t g;
    g = '0;
    g.dist_val = d;
    if (anchor_mid <= anchor_low || anchor_high <= anchor_mid) begin
      // anchors out of order: crisp split at mid
      g.crisp = 1'b1;
      if (d <= anchor_mid) g.similar = GRADE_ONE;
      else g.very = GRADE_ONE;
    end else begin
      if (d <= anchor_low) g.similar = GRADE_ONE;
      else if (d < anchor_mid) g.similar = scaled_ratio(anchor_mid - d, anchor_mid - anchor_low);

      if (d > anchor_low && d < anchor_mid)
        g.somewhat = scaled_ratio(d - anchor_low, anchor_mid - anchor_low);
      else if (d >= anchor_mid && d < anchor_high)
        g.somewhat = scaled_ratio(anchor_high - d, anchor_high - anchor_mid);

      if (d >= anchor_high) g.very = GRADE_ONE;
      else if (d > anchor_mid) g.very = scaled_ratio(d - anchor_mid, anchor_high - anchor_mid);
    end
    return g;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic cmp_field(input string name, input logic [tsf_pkg::WORD_W-1:0] dist_val,
                           input int unsigned got, input int unsigned want);
    if (got != want)
      report($sformatf("distance %h: %s got %0d, expected %0d", dist_val, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    grade_set_t want;
    if (!rst_n) begin
      anchor_low  = tsf_pkg::ANCHOR_LOW_RST;
      anchor_mid  = tsf_pkg::ANCHOR_MID_RST;
      anchor_high = tsf_pkg::ANCHOR_HIGH_RST;
      grades_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          tsf_pkg::REG_ANCHOR_LOW:  anchor_low  = cfg_ch.data;
          tsf_pkg::REG_ANCHOR_MID:  anchor_mid  = cfg_ch.data;
          tsf_pkg::REG_ANCHOR_HIGH: anchor_high = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (grades_due.size() == 0) begin
          report($sformatf("result with no request outstanding: %0d %0d %0d crisp %0b",
                           out_ch.grade_similar, out_ch.grade_somewhat,
                           out_ch.grade_very, out_ch.crisp_fallback));
        end else begin
          want = grades_due.pop_front();
          cmp_field("similar", want.dist_val, out_ch.grade_similar, want.similar);
          cmp_field("somewhat", want.dist_val, out_ch.grade_somewhat, want.somewhat);
          cmp_field("very", want.dist_val, out_ch.grade_very, want.very);
          cmp_field("crisp", want.dist_val, out_ch.crisp_fallback, want.crisp);
        end
      end
      if (in_ch.valid && in_ch.ready) grades_due.push_back(fuzzify(in_ch.distance));
    end
    n_pending <= grades_due.size();
  end

endmodule

### tb/three_set_fuzzifier_tb.sv
`timescale 1ns / 1ps
// Top of the three-set fuzzifier testbench: clock, reset, anchor settings, distance
// stimulus with random gaps on both sides, watchdog and verdict.
// Depends on tsf_pkg, tsf_if.sv, the design and three_set_fuzzifier_checker.
module three_set_fuzzifier_tb;

  localparam int FRAC_BITS      = 16;
  localparam int LATENCY        = FRAC_BITS + 2;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int N_RANDOM       = 100;
  localparam int N_FIXED        = 9;
  localparam int N_RAND_CFG     = 4;

  // index with no register behind it; writes there must be dropped
  localparam logic [tsf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // low, mid, high
  localparam logic [tsf_pkg::WORD_W-1:0] ANCHOR_PLAN [N_FIXED][3] = '{
    '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002},
    '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF},
    '{32'h0000_0064, 32'h0010_0000, 32'h0010_0001},
    '{32'h0003_0000, 32'h0003_0000, 32'h0005_0000},
    '{32'h0001_0000, 32'h0004_0000, 32'h0004_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
    '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}
  };

  logic        clk;
  logic        rst_n;
  int unsigned n_fail;
  int unsigned n_pending;
  bit          steady = 1'b0;

  logic [tsf_pkg::WORD_W-1:0] cur_low  = tsf_pkg::ANCHOR_LOW_RST;
  logic [tsf_pkg::WORD_W-1:0] cur_mid  = tsf_pkg::ANCHOR_MID_RST;
  logic [tsf_pkg::WORD_W-1:0] cur_high = tsf_pkg::ANCHOR_HIGH_RST;

  tsf_in_if  dist_ch ();
  tsf_out_if grade_ch ();
  tsf_cfg_if anchor_ch ();

  three_set_fuzzifier #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (dist_ch),
    .out_ch (grade_ch),
    .cfg_ch (anchor_ch)
  );

  three_set_fuzzifier_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (dist_ch),
    .out_ch    (grade_ch),
    .cfg_ch    (anchor_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly none, often a short one, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [tsf_pkg::WORD_W-1:0] pick_distance();
    int r;
    logic [tsf_pkg::WORD_W-1:0] base;
    r = $urandom_range(0, 9);
    if (r < 4 && cur_high > cur_low) return cur_low + $urandom_range(0, cur_high - cur_low);
    if (r < 7) begin
      case ($urandom_range(0, 2))
        0: base = cur_low;
        1: base = cur_mid;
        default: base = cur_high;
      endcase
      return base + $urandom_range(0, 8) - 4;
    end
    return $urandom;
  endfunction

  task automatic wait_drain();
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic send_distance(input logic [tsf_pkg::WORD_W-1:0] d);
    int gap;
    dist_ch.valid    <= 1'b1;
    dist_ch.distance <= d;
    do @(posedge clk); while (!dist_ch.ready);
    gap = steady ? 0 : draw_gap();
    if (gap > 0) begin
      dist_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_anchor(input logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tsf_pkg::WORD_W-1:0] val);
    anchor_ch.valid <= 1'b1;
    anchor_ch.index <= idx;
    anchor_ch.data  <= val;
    do @(posedge clk); while (!anchor_ch.ready);
  endtask

  task automatic set_anchors(input logic [tsf_pkg::WORD_W-1:0] lo,
                             input logic [tsf_pkg::WORD_W-1:0] mid,
                             input logic [tsf_pkg::WORD_W-1:0] hi);
    wait_drain();
    write_anchor(tsf_pkg::REG_ANCHOR_LOW, lo);
    write_anchor(tsf_pkg::REG_ANCHOR_MID, mid);
    write_anchor(tsf_pkg::REG_ANCHOR_HIGH, hi);
    write_anchor(REG_SPARE, $urandom);
    anchor_ch.valid <= 1'b0;
    cur_low  = lo;
    cur_mid  = mid;
    cur_high = hi;
  endtask

  task automatic run_phase();
    logic [tsf_pkg::WORD_W-1:0] probes [15];
    probes = '{32'h0000_0000, 32'hFFFF_FFFF, cur_low - 1, cur_low, cur_low + 1,
               cur_mid - 1, cur_mid, cur_mid + 1, cur_high - 1, cur_high, cur_high + 1,
               cur_low + (cur_mid - cur_low) / 2, cur_mid + (cur_high - cur_mid) / 2,
               32'h5555_5555, 32'hAAAA_AAAA};
    foreach (probes[i]) send_distance(probes[i]);
    repeat (N_RANDOM) send_distance(pick_distance());
    dist_ch.valid <= 1'b0;
  endtask

  // result side: random gaps, plus long hold-offs so the pipe backs up into the input
  initial begin : receiver
    int n_taken;
    int next_hold;
    int hold_left;
    int gap_left;
    n_taken   = 0;
    next_hold = 300;
    hold_left = 0;
    gap_left  = 0;
    grade_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (grade_ch.valid && grade_ch.ready) n_taken++;
      if (hold_left > 0) begin
        hold_left--;
        grade_ch.ready <= 1'b0;
      end else if (n_taken >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 800;
        grade_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        grade_ch.ready <= 1'b0;
      end else begin
        grade_ch.ready <= 1'b1;
        if (!steady) gap_left = draw_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((dist_ch.valid && dist_ch.ready) || (grade_ch.valid && grade_ch.ready) ||
          (anchor_ch.valid && anchor_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    logic [tsf_pkg::WORD_W-1:0] a, b, c, t;
    phase = 0;
    rst_n            = 1'b0;
    dist_ch.valid    = 1'b0;
    dist_ch.distance = '0;
    anchor_ch.valid  = 1'b0;
    anchor_ch.index  = tsf_pkg::REG_ANCHOR_LOW;
    anchor_ch.data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset anchors first, then the fixed corner settings
    run_phase();
    for (int i = 0; i < N_FIXED; i++) begin
      phase++;
      steady = (phase % 4 == 2);
      set_anchors(ANCHOR_PLAN[i][0], ANCHOR_PLAN[i][1], ANCHOR_PLAN[i][2]);
      run_phase();
    end

    // random anchors, mostly in order, sometimes not
    for (int i = 0; i < N_RAND_CFG; i++) begin
      phase++;
      steady = (phase % 4 == 2);
      a = $urandom >> $urandom_range(0, 31);
      b = $urandom >> $urandom_range(0, 31);
      c = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 3) != 0) begin
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
      end
      set_anchors(a, b, c);
      run_phase();
    end

    steady = 1'b0;
    wait_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
